### design/hcs_pkg.sv
// Package with shared types, constants and tables for the hall commutation block.
`default_nettype none
package hcs_pkg;

  localparam int SPEED_SAMPLES = 6;

  localparam logic [2:0] CFG_DIRECTION   = 3'd0;
  localparam logic [2:0] CFG_FAIL_LIMIT  = 3'd1;
  localparam logic [2:0] CFG_FAIL_WINDOW = 3'd2;
  localparam logic [2:0] CFG_TIMER_TOP   = 3'd3;
  localparam logic [2:0] CFG_SPEED_NUM   = 3'd4;

  localparam logic [2:0] POS_INVALID = 3'd6;
  localparam logic [1:0] PHASE_OFF   = 2'd3;

  // Result of the front part: everything but the speed step.
  typedef struct packed {
    logic [2:0]  position;
    logic [1:0]  high_phase;
    logic [1:0]  low_phase;
    logic        mismatch;
    logic        fault_pulse;
    logic        fault;
    logic [15:0] interval;
    logic        speed_go;
    logic [17:0] total;
  } hcs_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_ACC,
    BK_OUT
  } hcs_bk_state_t;

  function automatic logic [2:0] code_of_sector(input logic [2:0] pos);
    logic [2:0] c;
    unique case (pos)
      3'd0: c = 3'd1;
      3'd1: c = 3'd3;
      3'd2: c = 3'd2;
      3'd3: c = 3'd6;
      3'd4: c = 3'd4;
      3'd5: c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] sector_of_code(input logic [2:0] code);
    logic [2:0] p;
    unique case (code)
      3'd1: p = 3'd0;
      3'd3: p = 3'd1;
      3'd2: p = 3'd2;
      3'd6: p = 3'd3;
      3'd4: p = 3'd4;
      3'd5: p = 3'd5;
      default: p = POS_INVALID;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] cw_high(input logic [2:0] pos);
    logic [1:0] r;
    unique case (pos)
      3'd0: r = 2'd1;
      3'd1: r = 2'd2;
      3'd2: r = 2'd2;
      3'd3: r = 2'd0;
      3'd4: r = 2'd0;
      3'd5: r = 2'd1;
      default: r = PHASE_OFF;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cw_low(input logic [2:0] pos);
    logic [1:0] r;
    unique case (pos)
      3'd0: r = 2'd0;
      3'd1: r = 2'd0;
      3'd2: r = 2'd1;
      3'd3: r = 2'd1;
      3'd4: r = 2'd2;
      3'd5: r = 2'd2;
      default: r = PHASE_OFF;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/hcs_front.sv
// Front part: decode, hall sequence check and interval measurement.
`default_nettype none
module hcs_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       code,
  input  wire logic [15:0]      capture,
  input  wire logic             active,
  input  wire logic             direction,
  input  wire logic [7:0]       fail_limit,
  input  wire logic [15:0]      fail_window,
  input  wire logic [15:0]      timer_top,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output hcs_pkg::hcs_job_t     job
);

  logic [2:0]  expected_r, expected_nxt;
  logic [7:0]  fail_count_r, fail_count_nxt;
  logic [15:0] window_r, window_nxt;
  logic [15:0] last_cap_r;
  logic [15:0] hist0_r, hist1_r;
  logic        fault_r, fault_nxt;
  logic        q_valid_r;
  hcs_pkg::hcs_job_t q_r, q_nxt;

  logic [2:0]  pos, pos_next;
  logic [15:0] iv;
  logic [7:0]  fc_inc;
  logic        pulse;
  logic        take;

  // One-entry queue to the back part.
  assign in_ready  = !q_valid_r || job_ready;
  assign take      = in_valid && in_ready && active;
  assign job_valid = q_valid_r;
  assign job       = q_r;

  always_comb begin
    pos = hcs_pkg::sector_of_code(code);
    if (direction) begin
      pos_next = (pos == 3'd0) ? 3'd5 : pos - 3'd1;
    end else begin
      pos_next = (pos == 3'd5) ? 3'd0 : pos + 3'd1;
    end
    expected_nxt = (pos == hcs_pkg::POS_INVALID) ? 3'd0 : hcs_pkg::code_of_sector(pos_next);

    fc_inc = fail_count_r + 8'd1;
    pulse  = 1'b0;
    fail_count_nxt = fail_count_r;
    fault_nxt = fault_r;
    if (code != expected_r) begin
      fail_count_nxt = fc_inc;
      if (fc_inc >= fail_limit) begin
        pulse = 1'b1;
        fault_nxt = 1'b1;
        fail_count_nxt = 8'd0;
      end
    end
    window_nxt = window_r + 16'd1;
    if (window_nxt >= fail_window) begin
      window_nxt = 16'd0;
      fail_count_nxt = 8'd0;
    end

    if (last_cap_r >= capture) begin
      iv = last_cap_r - capture;
    end else begin
      iv = timer_top - capture + last_cap_r;
    end

    q_nxt.position    = pos;
    // The CCW high and low tables equal the CW low and high tables.
    q_nxt.high_phase  = direction ? hcs_pkg::cw_low(pos) : hcs_pkg::cw_high(pos);
    q_nxt.low_phase   = direction ? hcs_pkg::cw_high(pos) : hcs_pkg::cw_low(pos);
    q_nxt.mismatch    = (code != expected_r);
    q_nxt.fault_pulse = pulse;
    q_nxt.fault       = fault_nxt;
    q_nxt.interval    = iv;
    q_nxt.speed_go    = (iv != 16'd0) && (hist0_r != 16'd0) && (hist1_r != 16'd0);
    q_nxt.total       = {2'b00, iv} + {2'b00, hist0_r} + {2'b00, hist1_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r   <= 3'd0;
      fail_count_r <= 8'd0;
      window_r     <= 16'd0;
      last_cap_r   <= 16'd0;
      hist0_r      <= 16'd0;
      hist1_r      <= 16'd0;
      fault_r      <= 1'b0;
      q_valid_r    <= 1'b0;
    end else begin
      if (take) begin
        expected_r   <= expected_nxt;
        fail_count_r <= fail_count_nxt;
        window_r     <= window_nxt;
        last_cap_r   <= capture;
        hist1_r      <= hist0_r;
        hist0_r      <= iv;
        fault_r      <= fault_nxt;
        q_valid_r    <= 1'b1;
      end else if (job_ready) begin
        q_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

### design/hcs_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module hcs_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [17:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [31:0] q_r;
  logic [17:0] rem_r;
  logic [17:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [18:0] trial;
  logic [18:0] diff;

  assign trial    = {rem_r, q_r[31]};
  assign diff     = trial - {1'b0, dvs_r};
  assign quotient = q_r;
  assign done     = busy_r && (cnt_r == 6'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= 18'd0;
      dvs_r <= divisor;
    end else if (busy_r && cnt_r != 6'd0) begin
      if (!diff[18]) begin
        rem_r <= diff[17:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= trial[17:0];
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### design/hcs_back.sv
// Back part: speed division, trimmed-mean filter and result register.
`default_nettype none
module hcs_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  wire hcs_pkg::hcs_job_t job,
  input  wire logic [31:0]       speed_numerator,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [42:0]            out_data
);

  hcs_pkg::hcs_bk_state_t st_r, st_nxt;
  hcs_pkg::hcs_job_t      job_r;
  logic [18:0] sum_r, sum_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] max_r, max_nxt, min_r, min_nxt;
  logic [15:0] speed_r, speed_nxt;
  logic        sv_r, sv_nxt;
  logic        div_start, div_done;
  logic        start_r;
  logic [31:0] quot;
  logic [31:0] quot_r;
  logic [15:0] s;
  logic [18:0] trim;

  hcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (speed_numerator),
    .divisor  (job_r.total),
    .done     (div_done),
    .quotient (quot)
  );

  assign job_ready = (st_r == hcs_pkg::BK_IDLE);
  assign out_valid = (st_r == hcs_pkg::BK_OUT);
  assign out_data  = {sv_r, speed_r, job_r.interval, job_r.fault, job_r.fault_pulse,
                      job_r.mismatch, job_r.low_phase, job_r.high_phase, job_r.position};

  always_comb begin
    st_nxt    = st_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    speed_nxt = speed_r;
    sv_nxt    = sv_r;
    s         = (quot_r[31:16] != 16'd0) ? 16'hFFFF : quot_r[15:0];
    trim      = sum_nxt;
    unique case (st_r)
      hcs_pkg::BK_IDLE: begin
        if (job_valid) begin
          sv_nxt = 1'b0;
          if (job.speed_go) begin
            st_nxt = hcs_pkg::BK_DIV;
          end else begin
            st_nxt = hcs_pkg::BK_OUT;
          end
        end
      end
      hcs_pkg::BK_DIV: begin
        if (div_done) begin
          st_nxt = hcs_pkg::BK_ACC;
        end
      end
      hcs_pkg::BK_ACC: begin
        sum_nxt = sum_r + {3'b000, s};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_nxt == 3'd1) begin
          max_nxt = s;
          min_nxt = s;
        end else if (s > max_r) begin
          max_nxt = s;
        end else if (s < min_r) begin
          min_nxt = s;
        end
        trim = sum_nxt - {3'b000, max_nxt} - {3'b000, min_nxt};
        if (cnt_nxt >= 3'(hcs_pkg::SPEED_SAMPLES)) begin
          speed_nxt = trim[17:2];
          cnt_nxt   = 3'd0;
          sum_nxt   = 19'd0;
          sv_nxt    = 1'b1;
        end
        st_nxt = hcs_pkg::BK_OUT;
      end
      hcs_pkg::BK_OUT: begin
        if (out_ready) begin
          st_nxt = hcs_pkg::BK_IDLE;
        end
      end
      default: st_nxt = hcs_pkg::BK_IDLE;
    endcase
  end

  // The divider starts the cycle after the job is latched.
  assign div_start = start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= hcs_pkg::BK_IDLE;
      sum_r   <= 19'd0;
      cnt_r   <= 3'd0;
      max_r   <= 16'd0;
      min_r   <= 16'd0;
      speed_r <= 16'd0;
      sv_r    <= 1'b0;
      start_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      speed_r <= speed_nxt;
      sv_r    <= sv_nxt;
      start_r <= (st_r == hcs_pkg::BK_IDLE) && job_valid && job.speed_go;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == hcs_pkg::BK_IDLE && job_valid) begin
      job_r <= job;
    end
    if (div_done) begin
      quot_r <= quot;
    end
  end

endmodule
`default_nettype wire

### design/hall_commutation_with_speed.sv
// Top level of the hall commutation block with speed estimate.
// Usage: each hall edge is one transfer on the in_ channel; tdata carries
// hall_u, hall_v, hall_w, capture, active. A transfer with active low is
// dropped. Every active transfer yields one transfer on the out_ channel
// with sector, phases, fault flags, interval and the filtered speed.
// The front part decodes and checks the hall code in the accept cycle and
// hands a job to a one-entry queue; the back part runs the speed step.
// An event without a full interval history goes from the queue straight to
// the output register; an event with a speed sample first passes the serial
// divider, which produces one quotient bit per cycle, and the filter step.
// The front part accepts a new edge while the back part still works, so
// up to two events are in flight. When the receiver stalls, the result
// stays in the output register and the queue fills, then in_tready drops.
// Configuration transfers on cfg_ are always taken and take effect at once,
// so the host must write them only while no event is in flight; the block
// does not enforce this. Reset (rst_n low, synchronous) restores the
// register defaults and clears all history, counters and the fault flag.
`default_nettype none
module hall_commutation_with_speed (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // hall_u, hall_v, hall_w, capture[15:0], active
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // position[2:0], high_phase[1:0], low_phase[1:0], mismatch, fault_pulse,
  // fault, interval[15:0], speed[15:0], speed_valid
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic        direction_r;
  logic [7:0]  fail_limit_r;
  logic [15:0] fail_window_r;
  logic [15:0] timer_top_r;
  logic [31:0] speed_num_r;
  logic        job_valid, job_ready;
  hcs_pkg::hcs_job_t job;
  logic [42:0] res;

  assign cfg_ready = 1'b1;
  assign out_tdata = {5'd0, res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r   <= 1'b0;
      fail_limit_r  <= 8'd60;
      fail_window_r <= 16'd10000;
      timer_top_r   <= 16'hFFFF;
      speed_num_r   <= 32'd22500000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hcs_pkg::CFG_DIRECTION:   direction_r   <= cfg_data[0];
        hcs_pkg::CFG_FAIL_LIMIT:  fail_limit_r  <= cfg_data[7:0];
        hcs_pkg::CFG_FAIL_WINDOW: fail_window_r <= cfg_data[15:0];
        hcs_pkg::CFG_TIMER_TOP:   timer_top_r   <= cfg_data[15:0];
        hcs_pkg::CFG_SPEED_NUM:   speed_num_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  hcs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .code        ({in_tdata[1], in_tdata[0], in_tdata[2]}),
    .capture     (in_tdata[18:3]),
    .active      (in_tdata[19]),
    .direction   (direction_r),
    .fail_limit  (fail_limit_r),
    .fail_window (fail_window_r),
    .timer_top   (timer_top_r),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job)
  );

  hcs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .job             (job),
    .speed_numerator (speed_num_r),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_data        (res)
  );

endmodule
`default_nettype wire
